/* rtl/pdsp_pkg.sv */
// Package for the particle density and speed profiler.
// Holds item types, register and state codes and default sizes.
// No dependencies.
package pdsp_pkg;

  localparam int MAX_PER_AXIS_DEF = 16;
  localparam int MAX_BINS_DEF     = 4096;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [47:0] SUM_MAX   = 48'hFFFFFFFFFFFF;

  typedef enum logic [2:0] {
    RG_BINS_X  = 3'd0,
    RG_BINS_Y  = 3'd1,
    RG_BINS_Z  = 3'd2,
    RG_WIDTH_X = 3'd3,
    RG_WIDTH_Y = 3'd4,
    RG_WIDTH_Z = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic               active;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [11:0]        read_bin;
  } in_item_t;

  typedef struct packed {
    logic [11:0] bin_number;
    logic [23:0] particle_count;
    logic [31:0] mean_speed;
  } out_item_t;

  typedef struct packed {
    op_t                kind;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [11:0]        read_bin;
  } job_t;

  typedef struct packed {
    logic [4:0]  bins_x;
    logic [4:0]  bins_y;
    logic [4:0]  bins_z;
    logic [31:0] width_x;
    logic [31:0] width_y;
    logic [31:0] width_z;
  } cfg_t;

  typedef struct packed {
    logic [23:0] cnt;
    logic [47:0] sum;
  } bin_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_WAITDIV,
    ST_INDEX,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RD_RD,
    ST_RD_WR,
    ST_MEAN,
    ST_EMIT
  } state_t;

endpackage

/* rtl/pdsp_chan_if.sv */
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from pdsp_pkg.
interface pdsp_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pdsp_front.sv */
// Front end: accepts input transactions, drops inactive particles,
// and queues jobs for the back end. Depends on pdsp_pkg, pdsp_chan_if.
module pdsp_front import pdsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pdsp_chan_if.sink   in_ch,
  input  logic        hold,
  input  logic        pop,
  output job_t        job,
  output logic        job_valid
);

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       take, keep, push;
  job_t       entry;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold;
  assign take        = in_ch.valid && in_ch.ready;
  assign keep        = (in_ch.data.operation == OP_READ) || in_ch.data.active;
  assign push        = take && keep;

  always_comb begin
    entry.kind     = op_t'(in_ch.data.operation);
    entry.pos_x    = in_ch.data.pos_x;
    entry.pos_y    = in_ch.data.pos_y;
    entry.pos_z    = in_ch.data.pos_z;
    entry.vel_x    = in_ch.data.vel_x;
    entry.vel_y    = in_ch.data.vel_y;
    entry.vel_z    = in_ch.data.vel_z;
    entry.read_bin = in_ch.data.read_bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= entry;
  end

  assign job       = q_r[rp_r];
  assign job_valid = (cnt_r != 2'd0);

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> job_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue overfilled");

endmodule

/* rtl/pdsp_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing.
module pdsp_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   q_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     rem_sh, rem_nxt;
  logic            ge;

  assign rem_sh  = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

/* rtl/pdsp_back.sv */
// Back end: bins, speed, histogram update and read-out sequencer.
// Holds the bin store. Depends on pdsp_pkg, pdsp_chan_if, pdsp_div.
module pdsp_back import pdsp_pkg::*; #(
  parameter int MAX_PER_AXIS = MAX_PER_AXIS_DEF,
  parameter int MAX_BINS     = MAX_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  job_t        job,
  input  logic        job_valid,
  output logic        pop,
  output logic        clearing,
  pdsp_chan_if.source out_ch
);

  localparam int AXW = $clog2(MAX_PER_AXIS + 1);
  localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW  = 3 * AXW + $clog2(MAX_BINS + 1) + 12;

  state_t state_r, state_nxt;

  job_t             job_r;
  logic [2*AXW-1:0] nxy_r;
  logic [1:0]       sq_cnt_r;
  logic [63:0]      prod_r, acc_r, res_r, bit_r;
  logic [CW-1:0]    idx_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             inrange_r;
  logic [23:0]      cnt_r;
  bin_t             mem_q_r;
  bin_t             store_mem [MAX_BINS];
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic          mem_re, mem_we, div_start, mean_start, load_out;
  logic [AW-1:0] mem_ra, mem_wa;
  bin_t          mem_wd;

  function automatic logic [AXW-1:0] eff_bins(input logic [4:0] n);
    if (n == 5'd0) return AXW'(1);
    if (int'(n) > MAX_PER_AXIS) return AXW'(MAX_PER_AXIS);
    return AXW'(n);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - 32'(v)) : 32'(v);
  endfunction

  function automatic logic [31:0] eff_width(input logic [31:0] w);
    return (w == 32'd0) ? 32'd1 : w;
  endfunction

  logic [AXW-1:0] nx, ny, nz, bx, by, bz;
  logic [31:0]    qx, qy, qz;
  logic           bx_busy, by_busy, bz_busy, mean_busy;
  logic [47:0]    mean_q;

  assign nx = eff_bins(cfg.bins_x);
  assign ny = eff_bins(cfg.bins_y);
  assign nz = eff_bins(cfg.bins_z);

  pdsp_div #(.NW(32), .DW(32)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(job.pos_x),
    .divisor(eff_width(cfg.width_x)), .busy(bx_busy), .quotient(qx)
  );
  pdsp_div #(.NW(32), .DW(32)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(job.pos_y),
    .divisor(eff_width(cfg.width_y)), .busy(by_busy), .quotient(qy)
  );
  pdsp_div #(.NW(32), .DW(32)) u_div_z (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(job.pos_z),
    .divisor(eff_width(cfg.width_z)), .busy(bz_busy), .quotient(qz)
  );
  pdsp_div #(.NW(48), .DW(24)) u_div_mean (
    .clk(clk), .rst_n(rst_n), .start(mean_start), .dividend(mem_q_r.sum),
    .divisor(mem_q_r.cnt), .busy(mean_busy), .quotient(mean_q)
  );

  assign bx = (qx > 32'(nx) - 32'd1) ? AXW'(nx - 1'b1) : AXW'(qx);
  assign by = (qy > 32'(ny) - 32'd1) ? AXW'(ny - 1'b1) : AXW'(qy);
  assign bz = (qz > 32'(nz) - 32'd1) ? AXW'(nz - 1'b1) : AXW'(qz);

  logic [31:0] sq_sel;
  logic [63:0] root_t;
  logic        root_ge;
  logic        idx_ok, rb_ok;
  logic [48:0] sum_add;
  bin_t        upd;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_sel = abs32(job_r.vel_x);
      2'd1:    sq_sel = abs32(job_r.vel_y);
      2'd2:    sq_sel = abs32(job_r.vel_z);
      default: sq_sel = 32'd0;
    endcase
  end

  assign root_t  = res_r + bit_r;
  assign root_ge = acc_r >= root_t;
  assign idx_ok  = idx_r < CW'(MAX_BINS);
  assign rb_ok   = CW'(job_r.read_bin) < CW'(MAX_BINS);
  assign sum_add = {1'b0, mem_q_r.sum} + 49'(res_r[31:0]);

  always_comb begin
    upd.cnt = (mem_q_r.cnt == COUNT_MAX) ? COUNT_MAX : mem_q_r.cnt + 24'd1;
    upd.sum = sum_add[48] ? SUM_MAX : sum_add[47:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_cnt_r == AW'(MAX_BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (job_valid) state_nxt = (job.kind == OP_READ) ? ST_RD_RD : ST_SQUARE;
      end
      ST_SQUARE:  if (sq_cnt_r == 2'd3) state_nxt = ST_ROOT;
      ST_ROOT:    if (bit_r == 64'd1) state_nxt = ST_WAITDIV;
      ST_WAITDIV: if (!bx_busy && !by_busy && !bz_busy) state_nxt = ST_INDEX;
      ST_INDEX:   state_nxt = ST_UPD_RD;
      ST_UPD_RD:  state_nxt = idx_ok ? ST_UPD_WR : ST_IDLE;
      ST_UPD_WR:  state_nxt = ST_IDLE;
      ST_RD_RD:   state_nxt = ST_RD_WR;
      ST_RD_WR: begin
        state_nxt = (inrange_r && mem_q_r.cnt != 24'd0) ? ST_MEAN : ST_EMIT;
      end
      ST_MEAN:    if (!mean_busy) state_nxt = ST_EMIT;
      ST_EMIT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    mean_start = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_ra     = AW'(idx_r);
    mem_wa     = AW'(idx_r);
    mem_wd     = upd;
    load_out   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      ST_IDLE: begin
        pop       = job_valid;
        div_start = job_valid && (job.kind == OP_ADD);
      end
      ST_UPD_RD: mem_re = idx_ok;
      ST_UPD_WR: mem_we = 1'b1;
      ST_RD_RD: begin
        mem_re = rb_ok;
        mem_ra = AW'(job_r.read_bin);
      end
      ST_RD_WR: begin
        mem_we     = inrange_r;
        mem_wa     = AW'(job_r.read_bin);
        mem_wd     = '0;
        mean_start = inrange_r && (mem_q_r.cnt != 24'd0);
      end
      ST_EMIT:   load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign clearing = (state_r == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r    <= job;
      nxy_r    <= (2*AXW)'(nx) * (2*AXW)'(ny);
      sq_cnt_r <= 2'd0;
      prod_r   <= '0;
      acc_r    <= '0;
      res_r    <= '0;
      bit_r    <= 64'd1 << 62;
    end
    if (state_r == ST_SQUARE) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
      prod_r   <= {32'd0, sq_sel} * {32'd0, sq_sel};
      acc_r    <= acc_r + prod_r;
    end
    if (state_r == ST_ROOT) begin
      bit_r <= bit_r >> 2;
      if (root_ge) begin
        acc_r <= acc_r - root_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
    if (state_r == ST_INDEX) begin
      idx_r <= CW'(bx) + CW'(by) * CW'(nx) + CW'(bz) * CW'(nxy_r);
    end
    if (state_r == ST_RD_RD) inrange_r <= rb_ok;
    if (state_r == ST_RD_WR) cnt_r <= inrange_r ? mem_q_r.cnt : 24'd0;
    if (load_out) begin
      out_data_r.bin_number     <= job_r.read_bin;
      out_data_r.particle_count <= cnt_r;
      out_data_r.mean_speed     <= (cnt_r == 24'd0) ? 32'd0 :
                                   (mean_q[47:32] != 16'd0) ? 32'hFFFFFFFF : mean_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= store_mem[mem_ra];
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_IDLE |-> !mem_we)
    else $error("store written while idle");
  assert property (@(posedge clk) disable iff (!rst_n) pop |=> state_r != ST_IDLE)
    else $error("job taken but not worked");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside emit");
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !pop)
    else $error("job taken during clearing pass");

endmodule

/* rtl/particle_density_speed_profiler_top.sv */
// Add transaction: a 32-step square root runs alongside the 32-step bin dividers.
// Read transaction: an empty or out-of-range bin is emitted without division, else the
// 48-step mean divider runs first. One transaction at a time in the back end; a
// two-entry queue lets the input keep taking transactions meanwhile.
// After reset a clearing pass zeroes all MAX_BINS (4096) store entries;
// in_ch.ready stays low until it ends. Configuration registers reset at once.
module particle_density_speed_profiler_top import pdsp_pkg::*; #(
  parameter int MAX_PER_AXIS = MAX_PER_AXIS_DEF,
  parameter int MAX_BINS     = MAX_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pdsp_chan_if.sink   in_ch,
  pdsp_chan_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg_r;
  job_t job;
  logic job_valid, pop, clearing;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bins_x  <= 5'd1;
      cfg_r.bins_y  <= 5'd1;
      cfg_r.bins_z  <= 5'd1;
      cfg_r.width_x <= 32'd65536;
      cfg_r.width_y <= 32'd65536;
      cfg_r.width_z <= 32'd65536;
    end else if (wr_en) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        RG_BINS_X:  cfg_r.bins_x  <= cfg_pwdata[4:0];
        RG_BINS_Y:  cfg_r.bins_y  <= cfg_pwdata[4:0];
        RG_BINS_Z:  cfg_r.bins_z  <= cfg_pwdata[4:0];
        RG_WIDTH_X: cfg_r.width_x <= cfg_pwdata;
        RG_WIDTH_Y: cfg_r.width_y <= cfg_pwdata;
        RG_WIDTH_Z: cfg_r.width_z <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      RG_BINS_X:  cfg_prdata = {27'd0, cfg_r.bins_x};
      RG_BINS_Y:  cfg_prdata = {27'd0, cfg_r.bins_y};
      RG_BINS_Z:  cfg_prdata = {27'd0, cfg_r.bins_z};
      RG_WIDTH_X: cfg_prdata = cfg_r.width_x;
      RG_WIDTH_Y: cfg_prdata = cfg_r.width_y;
      RG_WIDTH_Z: cfg_prdata = cfg_r.width_z;
      default:    cfg_prdata = 32'd0;
    endcase
  end

  pdsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .hold(clearing),
    .pop(pop), .job(job), .job_valid(job_valid)
  );

  pdsp_back #(.MAX_PER_AXIS(MAX_PER_AXIS), .MAX_BINS(MAX_BINS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .job(job), .job_valid(job_valid),
    .pop(pop), .clearing(clearing), .out_ch(out_ch)
  );

endmodule

/* sim/particle_density_speed_profiler_top_tb.sv */
// Testbench for particle_density_speed_profiler_top: random and directed add/read
// transactions checked against a self-contained binning and mean-speed predictor.
// Depends on pdsp_pkg and pdsp_chan_if from the RTL.
module particle_density_speed_profiler_top_tb;
  import pdsp_pkg::*;

  class density_scoreboard;
    logic [4:0]  bins_reg [3];
    logic [31:0] width_reg [3];
    bit [23:0]   bin_count [4096];
    bit [47:0]   bin_speed_sum [4096];
    out_item_t   pending_reads [$];
    int          errors;
    int          adds_counted;
    int          reads_checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        bins_reg[i]  = 5'd1;
        width_reg[i] = 32'h10000;
      end
      for (int i = 0; i < 4096; i++) begin
        bin_count[i]     = '0;
        bin_speed_sum[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        RG_BINS_X:  bins_reg[0]  = v[4:0];
        RG_BINS_Y:  bins_reg[1]  = v[4:0];
        RG_BINS_Z:  bins_reg[2]  = v[4:0];
        RG_WIDTH_X: width_reg[0] = v;
        RG_WIDTH_Y: width_reg[1] = v;
        RG_WIDTH_Z: width_reg[2] = v;
        default: ;
      endcase
    endfunction

    function int axis_bins(int a);
      if (bins_reg[a] == 0) return 1;
      if (bins_reg[a] > 16) return 16;
      return bins_reg[a];
    endfunction

    function int axis_slot(int a, logic [31:0] pos);
      logic [31:0] w;
      logic [31:0] q;
      w = (width_reg[a] == 0) ? 32'd1 : width_reg[a];
      q = pos / w;
      return (q > axis_bins(a) - 1) ? axis_bins(a) - 1 : int'(q);
    endfunction

    function longint unsigned speed_of(logic signed [31:0] vx, logic signed [31:0] vy,
                                       logic signed [31:0] vz);
      longint unsigned ax, ay, az, sq, root, t;
      ax = (vx < 0) ? 64'(-64'(signed'(vx))) : 64'(vx);
      ay = (vy < 0) ? 64'(-64'(signed'(vy))) : 64'(vy);
      az = (vz < 0) ? 64'(-64'(signed'(vz))) : 64'(vz);
      sq = ax * ax + ay * ay + az * az;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        t = root | (64'd1 << b);
        if (t * t <= sq) root = t;
      end
      return root;
    endfunction

    function void note_input(in_item_t t);
      int idx;
      longint unsigned s;
      out_item_t r;
      if (t.operation == OP_ADD) begin
        if (!t.active) return;
        idx = axis_slot(0, t.pos_x) + axis_slot(1, t.pos_y) * axis_bins(0)
            + axis_slot(2, t.pos_z) * axis_bins(0) * axis_bins(1);
        if (idx >= 4096) return;
        if (bin_count[idx] != COUNT_MAX) bin_count[idx]++;
        s = 64'(bin_speed_sum[idx]) + speed_of(t.vel_x, t.vel_y, t.vel_z);
        bin_speed_sum[idx] = (s > 64'(SUM_MAX)) ? SUM_MAX : s[47:0];
        adds_counted++;
      end else begin
        idx = t.read_bin;
        r.bin_number     = t.read_bin;
        r.particle_count = bin_count[idx];
        if (bin_count[idx] == 0) begin
          r.mean_speed = '0;
        end else begin
          s = 64'(bin_speed_sum[idx]) / 64'(bin_count[idx]);
          r.mean_speed = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
        end
        bin_count[idx]     = '0;
        bin_speed_sum[idx] = '0;
        pending_reads.push_back(r);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_reads.size() == 0) begin
        $error("unexpected result for bin %0d", got.bin_number);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got.bin_number !== want.bin_number) begin
        $error("bin_number expected %0d actual %0d", want.bin_number, got.bin_number);
        errors++;
      end
      if (got.particle_count !== want.particle_count) begin
        $error("particle_count expected %0d actual %0d", want.particle_count,
               got.particle_count);
        errors++;
      end
      if (got.mean_speed !== want.mean_speed) begin
        $error("mean_speed expected %0d actual %0d", want.mean_speed, got.mean_speed);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pdsp_chan_if #(.T(in_item_t))  in_ch ();
  pdsp_chan_if #(.T(out_item_t)) out_ch ();

  particle_density_speed_profiler_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  density_scoreboard profile_sb;
  bit no_gaps;
  bit hold_results;
  int items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20000000;
    $display("** particle_density_speed_profiler_top: FAILED **");
    $finish;
  end

  initial begin
    int pause;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (800) @(negedge clk);
        hold_results = 1'b0;
      end
      pause = no_gaps ? 0 : $urandom_range(0, 19);
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) profile_sb.check_result(out_ch.data);
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(r) << 2;
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    profile_sb.set_reg(r, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(logic [4:0] nx, logic [4:0] ny, logic [4:0] nz,
                           logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
    write_reg(RG_BINS_X, nx);
    write_reg(RG_BINS_Y, ny);
    write_reg(RG_BINS_Z, nz);
    write_reg(RG_WIDTH_X, wx);
    write_reg(RG_WIDTH_Y, wy);
    write_reg(RG_WIDTH_Z, wz);
  endtask

  task automatic send(in_item_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    profile_sb.note_input(t);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (profile_sb.pending_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] place(logic [31:0] w, logic [4:0] n);
    longint unsigned ww, p;
    ww = (w == 0) ? 1 : w;
    p = ww * $urandom_range(0, (n == 0 ? 1 : n) + 1) + ($urandom() % ww);
    return (p > 64'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
  endfunction

  function automatic in_item_t particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    in_item_t t;
    t.operation = OP_ADD;
    t.active    = 1'b1;
    t.pos_x = px; t.pos_y = py; t.pos_z = pz;
    t.vel_x = vx; t.vel_y = vy; t.vel_z = vz;
    t.read_bin = 12'($urandom());
    return t;
  endfunction

  function automatic in_item_t bin_read(logic [11:0] b);
    in_item_t t;
    t = particle($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    t.operation = OP_READ;
    t.active    = 1'($urandom());
    t.read_bin  = b;
    return t;
  endfunction

  task automatic random_phase(int n, int span);
    in_item_t t;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        t = particle(place(profile_sb.width_reg[0], profile_sb.bins_reg[0]),
                     place(profile_sb.width_reg[1], profile_sb.bins_reg[1]),
                     place(profile_sb.width_reg[2], profile_sb.bins_reg[2]),
                     $urandom(), $urandom(), $urandom());
        if ($urandom_range(0, 9) == 0) t.pos_x = $urandom();
      end else if (pick < 65) begin
        t = particle($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        t.active = 1'b0;
      end else if (pick < 93) begin
        t = bin_read(12'($urandom_range(0, span - 1)));
      end else begin
        t = bin_read(12'($urandom()));
      end
      send(t);
    end
  endtask

  initial begin
    in_item_t t;
    profile_sb = new();
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    no_gaps = 1'b0;
    hold_results = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send(bin_read(12'd0));
    send(particle(32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000));
    send(particle(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF));
    send(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    t = particle(32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0);
    t.active = 1'b0;
    send(t);
    send(bin_read(12'd0));
    send(bin_read(12'd0));
    send(bin_read(12'hFFF));
    drain();

    configure(5'd31, 5'd16, 5'd0, 32'h0, 32'hFFFFFFFF, 32'h1);
    send(particle(32'd3, 32'h0, 32'h5, 32'h00030000, 32'hFFFC0000, 32'h0));
    send(particle(32'd20, 32'hFFFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h0));
    send(particle(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h0, 32'h0));
    send(bin_read(12'd3));
    send(bin_read(12'd15));
    send(bin_read(12'd255));
    drain();

    configure(5'd16, 5'd16, 5'd16, 32'h1, 32'h1, 32'h1);
    send(particle(32'd15, 32'd15, 32'd15, $urandom(), $urandom(), $urandom()));
    send(particle(32'd15, 32'd15, 32'd15, $urandom(), $urandom(), $urandom()));
    send(bin_read(12'd4095));
    send(bin_read(12'd4095));
    drain();

    hold_results = 1'b1;
    configure(5'd2, 5'd2, 5'd1, 32'h00010000, 32'h00020000, 32'h00010000);
    random_phase(160, 8);
    drain();

    no_gaps = 1'b1;
    configure(5'd3, 5'd1, 5'd2, 32'h00008000, 32'h00010000, 32'hFFFFFFFF);
    random_phase(120, 6);
    drain();

    no_gaps = 1'b0;
    configure(5'd16, 5'd16, 5'd16, 32'h00100000, 32'h00100000, 32'h00100000);
    random_phase(120, 64);
    drain();

    configure(5'd1, 5'd4, 5'd3, 32'h7FFFFFFF, 32'h00004000, 32'h00000100);
    random_phase(120, 12);
    drain();

    configure(5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 32'h0);
    random_phase(110, 2);
    drain();

    $display("Sent %0d transactions over seven register settings: %0d particles binned,",
             items_sent, profile_sb.adds_counted);
    $display("%0d bin reads checked.", profile_sb.reads_checked);
    if (profile_sb.errors == 0 && profile_sb.pending_reads.size() == 0) begin
      $display("** particle_density_speed_profiler_top: PASSED **");
    end else begin
      $display("** particle_density_speed_profiler_top: FAILED **");
    end
    $finish;
  end

endmodule
